FILE: src/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg: shared types for the shifting array list
// Operation and status codes, and the request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

package sal_pkg;

  typedef enum logic [2:0] {
    OP_READ_AT      = 3'd0,
    OP_SEARCH       = 3'd1,
    OP_INSERT_FRONT = 3'd2,
    OP_INSERT_END   = 3'd3,
    OP_INSERT_AT    = 3'd4,
    OP_DELETE_FIRST = 3'd5,
    OP_DELETE_LAST  = 3'd6,
    OP_DELETE_AT    = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    op_e                operation;
    logic [6:0]         position;
    logic signed [31:0] item_value;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] data_out;
    logic [5:0]         found_index;
    logic [6:0]         element_total;
  } out_word_t;

endpackage

`default_nettype wire

FILE: src/shifting_array_list.sv
// ----------------------------------------------------------------------------
// shifting_array_list: dense list of signed words with insert, delete, search
// Top level: sequencer, entry memory and response register.
// ----------------------------------------------------------------------------
// One request is handled at a time. The entry memory has a single read and
// a single write port and moves one entry per cycle. With n stored words and
// index p, read_at reads entry p, a search reads from entry 0 to a match or
// entry n - 1, an insert moves entries n - 1 down to p up by one and writes p,
// and a delete reads p and moves each later entry down; errors go straight to
// the response. The response register lets the next request be accepted while
// a response word still waits. No clearing pass follows reset.
`default_nettype none

module shifting_array_list #(
  parameter int DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire sal_pkg::in_word_t  req,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output sal_pkg::out_word_t      rsp
);

  localparam int AW = $clog2(DEPTH);

  logic               res_valid;
  sal_pkg::out_word_t res;
  logic               out_free;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [31:0]        mem_wdata, mem_rdata;

  assign out_free = !rsp_valid || rsp_ready;

  sal_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sal_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (res_valid && out_free) begin
      rsp <= res;
    end
  end

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != sal_pkg::ST_OK) |-> rsp.data_out == '0)
    else $error("error response carries a data word");

  a_idle_or_done: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && res_valid))
    else $error("sequencer idle and holding a word at once");

  a_word_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_free |=> res_valid && $stable(res))
    else $error("pending word lost while response register was full");

  a_no_mem_collide: assert property (@(posedge clk) disable iff (rst)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("read and write on the same entry in one cycle");

endmodule

`default_nettype wire

FILE: src/sal_mem.sv
// ----------------------------------------------------------------------------
// sal_mem: entry storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sal_mem #(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [31:0]              wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [31:0]                   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/sal_ctrl.sv
// ----------------------------------------------------------------------------
// sal_ctrl: list sequencer
// Decodes a request, walks the entry memory one address per cycle and builds
// the response word.
// ----------------------------------------------------------------------------
`default_nettype none

module sal_ctrl #(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  output logic                          req_ready,
  input  wire sal_pkg::in_word_t        req,
  output logic                          res_valid,
  output sal_pkg::out_word_t            res,
  input  wire logic                     out_free,
  output logic                          mem_we,
  output logic [$clog2(DEPTH)-1:0]      mem_waddr,
  output logic [31:0]                   mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(DEPTH)-1:0]      mem_raddr,
  input  wire logic [31:0]              mem_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_READ     = 7'b0000010,
    S_SEARCH   = 7'b0000100,
    S_SHIFT_UP = 7'b0001000,
    S_PUT      = 7'b0010000,
    S_SHIFT_DN = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [AW-1:0]      pos, pos_next;
  logic [31:0]        key, key_next;
  logic [AW-1:0]      rd_tag, rd_tag_next;
  logic [31:0]        removed, removed_next;
  sal_pkg::out_word_t res_next;

  logic [XW-1:0] cnt_x, last_x, eff_x, tag_x;
  logic          is_last, at_pos;

  function automatic sal_pkg::out_word_t make_res(sal_pkg::status_e st, logic [31:0] d,
                                                  logic [XW-1:0] fi, logic [XW-1:0] tot);
    sal_pkg::out_word_t r;
    r.status        = st;
    r.data_out      = d;
    r.found_index   = fi[5:0];
    r.element_total = tot[6:0];
    return r;
  endfunction

  assign cnt_x   = XW'(cnt);
  assign last_x  = cnt_x - XW'(1);
  assign tag_x   = XW'(rd_tag);
  assign is_last = (tag_x == last_x);
  assign at_pos  = (rd_tag == pos);

  always_comb begin
    unique case (req.operation)
      sal_pkg::OP_INSERT_FRONT, sal_pkg::OP_DELETE_FIRST: eff_x = '0;
      sal_pkg::OP_INSERT_END:                             eff_x = cnt_x;
      sal_pkg::OP_DELETE_LAST:                            eff_x = last_x;
      sal_pkg::OP_READ_AT, sal_pkg::OP_SEARCH, sal_pkg::OP_INSERT_AT,
      sal_pkg::OP_DELETE_AT:                              eff_x = XW'(req.position);
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // Shift walks read two addresses ahead of the one they write, so a read and a
  // write never meet on the same entry in one cycle.
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    pos_next     = pos;
    key_next     = key;
    rd_tag_next  = rd_tag;
    removed_next = removed;
    res_next     = res;
    mem_we       = 1'b0;
    mem_waddr    = rd_tag;
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;
    mem_raddr    = rd_tag;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          key_next = req.item_value;
          pos_next = eff_x[AW-1:0];
          unique case (req.operation)
            sal_pkg::OP_READ_AT: begin
              if (cnt == '0) begin
                res_next   = make_res(sal_pkg::ST_EMPTY, '0, '0, cnt_x);
                state_next = S_DONE;
              end else if (eff_x >= cnt_x) begin
                res_next   = make_res(sal_pkg::ST_BADIDX, '0, '0, cnt_x);
                state_next = S_DONE;
              end else begin
                mem_re      = 1'b1;
                mem_raddr   = eff_x[AW-1:0];
                rd_tag_next = eff_x[AW-1:0];
                state_next  = S_READ;
              end
            end
            sal_pkg::OP_SEARCH: begin
              if (cnt == '0) begin
                res_next   = make_res(sal_pkg::ST_NOTFOUND, '0, '0, cnt_x);
                state_next = S_DONE;
              end else begin
                mem_re      = 1'b1;
                mem_raddr   = '0;
                rd_tag_next = '0;
                state_next  = S_SEARCH;
              end
            end
            sal_pkg::OP_INSERT_FRONT, sal_pkg::OP_INSERT_END, sal_pkg::OP_INSERT_AT: begin
              if (cnt_x == XW'(DEPTH)) begin
                res_next   = make_res(sal_pkg::ST_FULL, '0, '0, cnt_x);
                state_next = S_DONE;
              end else if (eff_x > cnt_x) begin
                res_next   = make_res(sal_pkg::ST_BADIDX, '0, '0, cnt_x);
                state_next = S_DONE;
              end else if (eff_x == cnt_x) begin
                state_next = S_PUT;
              end else begin
                mem_re      = 1'b1;
                mem_raddr   = last_x[AW-1:0];
                rd_tag_next = last_x[AW-1:0];
                state_next  = S_SHIFT_UP;
              end
            end
            sal_pkg::OP_DELETE_FIRST, sal_pkg::OP_DELETE_LAST, sal_pkg::OP_DELETE_AT: begin
              if (cnt == '0) begin
                res_next   = make_res(sal_pkg::ST_EMPTY, '0, '0, cnt_x);
                state_next = S_DONE;
              end else if (eff_x >= cnt_x) begin
                res_next   = make_res(sal_pkg::ST_BADIDX, '0, '0, cnt_x);
                state_next = S_DONE;
              end else begin
                mem_re      = 1'b1;
                mem_raddr   = eff_x[AW-1:0];
                rd_tag_next = eff_x[AW-1:0];
                state_next  = S_SHIFT_DN;
              end
            end
          endcase
        end
      end
      S_READ: begin
        res_next   = make_res(sal_pkg::ST_OK, mem_rdata, '0, cnt_x);
        state_next = S_DONE;
      end
      S_SEARCH: begin
        if (mem_rdata == key) begin
          res_next   = make_res(sal_pkg::ST_OK, '0, tag_x, cnt_x);
          state_next = S_DONE;
        end else if (is_last) begin
          res_next   = make_res(sal_pkg::ST_NOTFOUND, '0, '0, cnt_x);
          state_next = S_DONE;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = rd_tag + AW'(1);
          rd_tag_next = rd_tag + AW'(1);
        end
      end
      S_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_waddr = rd_tag + AW'(1);
        if (at_pos) begin
          state_next = S_PUT;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = rd_tag - AW'(1);
          rd_tag_next = rd_tag - AW'(1);
        end
      end
      S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = pos;
        mem_wdata  = key;
        cnt_next   = cnt + CW'(1);
        res_next   = make_res(sal_pkg::ST_OK, '0, '0, cnt_x + XW'(1));
        state_next = S_DONE;
      end
      S_SHIFT_DN: begin
        if (at_pos) begin
          removed_next = mem_rdata;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = rd_tag - AW'(1);
        end
        if (is_last) begin
          cnt_next   = cnt - CW'(1);
          res_next   = make_res(sal_pkg::ST_OK, at_pos ? mem_rdata : removed, '0, last_x);
          state_next = S_DONE;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = rd_tag + AW'(1);
          rd_tag_next = rd_tag + AW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
    pos     <= pos_next;
    key     <= key_next;
    rd_tag  <= rd_tag_next;
    removed <= removed_next;
    res     <= res_next;
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_shifting_array_list.sv
// ----------------------------------------------------------------------------
// tb_shifting_array_list: self-checking testbench for the shifting array list
// A directed opening covers the empty and bad-index cases and both ends of the
// value range. Random phases then grow, drain and churn the list while either
// side may idle in short bursts. A scoreboard class keeps a shadow copy of
// the list and compares every response word with its prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_shifting_array_list;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;
  localparam int MODE_FILL   = 3;
  localparam int MODE_DRAIN  = 4;

  class list_scoreboard;
    localparam int ListDepth = 64;

    logic signed [31:0]  shadow_list [ListDepth];
    int                  shadow_count;
    sal_pkg::out_word_t  expected_rsp [$];
    int                  errors;

    function new();
      shadow_count = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    function void apply_request(sal_pkg::in_word_t w);
      sal_pkg::out_word_t r;
      int                 p;
      r.status = sal_pkg::ST_OK;
      r.data_out = '0;
      r.found_index = '0;
      p = int'(w.position);
      case (w.operation)
        sal_pkg::OP_READ_AT: begin
          if (shadow_count == 0) r.status = sal_pkg::ST_EMPTY;
          else if (p >= shadow_count) r.status = sal_pkg::ST_BADIDX;
          else r.data_out = shadow_list[6'(p)];
        end
        sal_pkg::OP_SEARCH: begin
          r.status = sal_pkg::ST_NOTFOUND;
          for (int k = 0; k < shadow_count; k++) begin
            if (r.status == sal_pkg::ST_NOTFOUND && shadow_list[6'(k)] == w.item_value) begin
              r.status = sal_pkg::ST_OK;
              r.found_index = k[5:0];
            end
          end
        end
        sal_pkg::OP_INSERT_FRONT, sal_pkg::OP_INSERT_END, sal_pkg::OP_INSERT_AT: begin
          if (w.operation == sal_pkg::OP_INSERT_FRONT) p = 0;
          else if (w.operation == sal_pkg::OP_INSERT_END) p = shadow_count;
          if (shadow_count >= ListDepth) begin
            r.status = sal_pkg::ST_FULL;
          end else if (p > shadow_count) begin
            r.status = sal_pkg::ST_BADIDX;
          end else begin
            for (int k = shadow_count; k > p; k--) begin
              shadow_list[6'(k)] = shadow_list[6'(k - 1)];
            end
            shadow_list[6'(p)] = w.item_value;
            shadow_count++;
          end
        end
        default: begin
          if (shadow_count == 0) begin
            r.status = sal_pkg::ST_EMPTY;
          end else begin
            if (w.operation == sal_pkg::OP_DELETE_FIRST) p = 0;
            else if (w.operation == sal_pkg::OP_DELETE_LAST) p = shadow_count - 1;
            if (p >= shadow_count) begin
              r.status = sal_pkg::ST_BADIDX;
            end else begin
              r.data_out = shadow_list[6'(p)];
              for (int k = p; k + 1 < shadow_count; k++) begin
                shadow_list[6'(k)] = shadow_list[6'(k + 1)];
              end
              shadow_count--;
            end
          end
        end
      endcase
      r.element_total = shadow_count[6:0];
      expected_rsp.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_response(sal_pkg::out_word_t got);
      sal_pkg::out_word_t want;
      if (expected_rsp.size() == 0) begin
        $error("response word with no request outstanding: %h", got);
        errors++;
        return;
      end
      want = expected_rsp.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("data_out", want.data_out, got.data_out);
      check_field("found_index", 32'(want.found_index), 32'(got.found_index));
      check_field("element_total", 32'(want.element_total), 32'(got.element_total));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  sal_pkg::in_word_t  req = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  sal_pkg::out_word_t rsp;

  list_scoreboard sb = new();

  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  bit long_hold_request = 1'b0;
  int ready_hold = 0;
  int words_sent = 0;

  shifting_array_list #(.DEPTH(64)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (ready_hold > 0) begin
        rsp_ready <= 1'b0;
        ready_hold--;
      end else if (long_hold_request) begin
        long_hold_request = 1'b0;
        rsp_ready <= 1'b0;
        ready_hold = 400;
      end else if (recv_idle && $urandom_range(0, 4) == 0) begin
        rsp_ready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input sal_pkg::in_word_t w);
    req <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.apply_request(w);
    words_sent++;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_op(input sal_pkg::op_e op, input int pos, input logic [31:0] val);
    sal_pkg::in_word_t w;
    w.operation = op;
    w.position = pos[6:0];
    w.item_value = val;
    send_word(w);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(input bit is_key);
    int r;
    r = $urandom_range(0, 9);
    if (sb.shadow_count > 0 && (r >= 8 || (is_key && r >= 3)))
      return sb.shadow_list[6'($urandom_range(0, sb.shadow_count - 1))];
    if (r == 7) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (r >= 5) return $urandom_range(0, 3) - 2;
    return $urandom;
  endfunction

  function automatic sal_pkg::in_word_t random_word(input int mode);
    sal_pkg::in_word_t w;
    int                r;
    int                n;
    bit                is_insert;
    n = sb.shadow_count;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW:
        w.operation = r < 60 ? sal_pkg::op_e'($urandom_range(2, 4)) :
                      r < 85 ? sal_pkg::op_e'($urandom_range(0, 1)) :
                               sal_pkg::op_e'($urandom_range(5, 7));
      MODE_SHRINK:
        w.operation = r < 60 ? sal_pkg::op_e'($urandom_range(5, 7)) :
                      r < 85 ? sal_pkg::op_e'($urandom_range(0, 1)) :
                               sal_pkg::op_e'($urandom_range(2, 4));
      MODE_FILL:
        w.operation = r < 90 ? sal_pkg::op_e'($urandom_range(2, 4)) :
                               sal_pkg::op_e'($urandom_range(0, 1));
      MODE_DRAIN:
        w.operation = r < 90 ? sal_pkg::op_e'($urandom_range(5, 7)) :
                               sal_pkg::op_e'($urandom_range(0, 1));
      default:
        w.operation = sal_pkg::op_e'($urandom_range(0, 7));
    endcase
    is_insert = w.operation inside {sal_pkg::OP_INSERT_FRONT, sal_pkg::OP_INSERT_END,
                                    sal_pkg::OP_INSERT_AT};
    r = $urandom_range(0, 9);
    if (r == 0) w.position = 7'($urandom_range(0, 127));
    else if (r == 1) w.position = n[6:0];
    else if (is_insert) w.position = 7'($urandom_range(0, n));
    else w.position = n > 0 ? 7'($urandom_range(0, n - 1)) : 7'd0;
    w.item_value = pick_value(w.operation == sal_pkg::OP_SEARCH);
    return w;
  endfunction

  initial begin
    int phase;
    int span;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_op(sal_pkg::OP_READ_AT, 0, 0);
    send_op(sal_pkg::OP_SEARCH, 0, 0);
    send_op(sal_pkg::OP_DELETE_FIRST, 0, 0);
    send_op(sal_pkg::OP_DELETE_LAST, 0, 0);
    send_op(sal_pkg::OP_DELETE_AT, 0, 0);
    send_op(sal_pkg::OP_INSERT_AT, 1, 5);
    send_op(sal_pkg::OP_INSERT_END, 0, 32'h7FFF_FFFF);
    send_op(sal_pkg::OP_INSERT_FRONT, 0, 32'h8000_0000);
    send_op(sal_pkg::OP_INSERT_AT, 2, 0);
    send_op(sal_pkg::OP_INSERT_AT, 1, -1);
    send_op(sal_pkg::OP_INSERT_END, 0, -1);
    send_op(sal_pkg::OP_INSERT_AT, 127, 3);
    send_op(sal_pkg::OP_READ_AT, 0, 0);
    send_op(sal_pkg::OP_READ_AT, 4, 0);
    send_op(sal_pkg::OP_READ_AT, 5, 0);
    send_op(sal_pkg::OP_READ_AT, 127, 0);
    send_op(sal_pkg::OP_SEARCH, 0, -1);
    send_op(sal_pkg::OP_SEARCH, 127, 32'h7FFF_FFFF);
    send_op(sal_pkg::OP_SEARCH, 0, 12345);
    send_op(sal_pkg::OP_DELETE_AT, 5, 0);
    send_op(sal_pkg::OP_DELETE_AT, 127, 0);
    send_op(sal_pkg::OP_DELETE_AT, 1, 0);
    send_op(sal_pkg::OP_DELETE_FIRST, 0, 0);
    send_op(sal_pkg::OP_DELETE_LAST, 0, 0);
    send_op(sal_pkg::OP_DELETE_AT, 0, 0);

    // Hold the response side off long enough that the request side backs up.
    long_hold_request = 1'b1;
    repeat (40) send_word(random_word(MODE_GROW));
    wait_drained();

    while (words_sent < 1400) begin
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      phase = $urandom_range(0, 5);
      span = $urandom_range(20, 80);
      if (phase == 0) begin
        while (sb.shadow_count < 64) send_word(random_word(MODE_FILL));
        repeat (12) send_word(random_word(MODE_FILL));
      end else if (phase == 1) begin
        while (sb.shadow_count > 0) send_word(random_word(MODE_DRAIN));
        repeat (6) send_word(random_word(MODE_DRAIN));
      end else if (phase == 2) begin
        repeat (span) send_word(random_word(MODE_GROW));
      end else if (phase == 3) begin
        repeat (span) send_word(random_word(MODE_SHRINK));
      end else begin
        repeat (span) send_word(random_word(MODE_MIXED));
      end
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    send_idle = 1'b0;
    recv_idle = 1'b0;
    repeat (150) send_word(random_word(MODE_MIXED));

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
